@@ design/rau_pkg.sv @@
// Package for the rational arithmetic unit: widths, action and compare codes,
// sequencer states and the status struct shared by the iterative units.
// No dependencies.
package rau_pkg;

   localparam int DW = 32;                 // operand width
   localparam int PW = 2 * DW;             // product / magnitude width
   localparam int KW = $clog2(PW);         // shift count and bit counter width

   localparam logic [2:0] ACT_NORM = 3'd0;
   localparam logic [2:0] ACT_ADD  = 3'd1;
   localparam logic [2:0] ACT_SUB  = 3'd2;
   localparam logic [2:0] ACT_MUL  = 3'd3;
   localparam logic [2:0] ACT_DIV  = 3'd4;
   localparam logic [2:0] ACT_INV  = 3'd5;
   localparam logic [2:0] ACT_CMP  = 3'd6;
   localparam logic [2:0] ACT_NONE = 3'd7;  // unused code, answers undefined

   localparam logic [1:0] CMP_EQ  = 2'd0;
   localparam logic [1:0] CMP_AGT = 2'd1;
   localparam logic [1:0] CMP_BGT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_SUM, ST_GCD, ST_DIVN, ST_DIVD, ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      K_UNDEF, K_ZERO, K_CMP, K_FRAC
   } kind_type;

   typedef struct packed {
      logic neg;
      logic [DW-1:0] mag;
   } opnd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

@@ design/rational_arithmetic_unit.sv @@
// Sequence: compare, undefined and zero results take only the products and the
// combine step; a reduced fraction adds the binary gcd (one step per cycle) and
// two divisions by the gcd, first of the numerator, then of the denominator.
// Throughput: one transaction at a time; the next is taken once the result is
// in the output register. Reset is synchronous, active high, and clears the
// sequencer and the output valid; no memory needs clearing.
module rational_arithmetic_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_action,
   input  logic signed [31:0]          req_a_num,
   input  logic signed [31:0]          req_a_den,
   input  logic signed [31:0]          req_b_num,
   input  logic signed [31:0]          req_b_den,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [31:0]          rsp_res_num,
   output logic [30:0]                 rsp_res_den,
   output logic [1:0]                  rsp_cmp_code,
   output logic                        rsp_overflow
);

   localparam logic [rau_pkg::PW-1:0] HALF = rau_pkg::PW'(1) << (rau_pkg::DW - 1);

   rau_pkg::state_type       state_ff, state_in;
   logic [2:0]               act_ff;
   logic [rau_pkg::DW-1:0]   an_ff, ad_ff, bn_ff, bd_ff;
   logic [1:0]               cnt_ff;
   logic                     pend_neg_ff;
   logic [rau_pkg::PW-1:0]   p_mag_ff [3];
   logic                     p_neg_ff [3];
   logic [rau_pkg::PW-1:0]   n_mag_ff, d_mag_ff, g_ff, qn_ff;
   logic                     n_neg_ff, d_neg_ff;
   rau_pkg::kind_type        kind_ff, kind_c;
   logic [1:0]               cmp_ff, cmp_c;
   logic                     rsp_valid_ff;
   logic [rau_pkg::DW-1:0]   res_num_ff, res_num_c;
   logic [rau_pkg::DW-2:0]   res_den_ff, res_den_c;
   logic [1:0]               cmp_code_ff;
   logic                     ovf_ff, ovf_c;

   // sequencer strobes
   logic accept, mul_issue, mul_capture, gcd_start, div_start, out_free, out_load;

   rau_pkg::opnd_type        mx, my;
   logic [rau_pkg::PW-1:0]   prod, gcd_val, quotient, div_a, div_b;
   rau_pkg::unit_stat_type   gcd_stat, div_stat;

   function automatic rau_pkg::opnd_type to_opnd(logic [rau_pkg::DW-1:0] v);
      rau_pkg::opnd_type r;
      r.neg = v[rau_pkg::DW-1];
      r.mag = v[rau_pkg::DW-1] ? (~v + 1'b1) : v;
      return r;
   endfunction

   // ---------------- operand selection for the shared multiplier
   always_comb begin
      rau_pkg::opnd_type one, oan, oad, obn, obd, x0, y0, x1, y1, x2, y2;
      one = '{neg: 1'b0, mag: rau_pkg::DW'(1)};
      oan = to_opnd(an_ff);
      oad = to_opnd(ad_ff);
      obn = to_opnd(bn_ff);
      obd = to_opnd(bd_ff);
      x0 = one; y0 = one; x1 = one; y1 = one; x2 = one; y2 = one;
      case (act_ff)
         rau_pkg::ACT_NORM: begin
            x0 = oan; x1 = oad;
         end
         rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
            x0 = oan; y0 = obd; x1 = obn; y1 = oad; x2 = oad; y2 = obd;
         end
         rau_pkg::ACT_MUL: begin
            x0 = oan; y0 = obn; x1 = oad; y1 = obd;
         end
         rau_pkg::ACT_DIV: begin
            x0 = oan; y0 = obd; x1 = oad; y1 = obn;
         end
         rau_pkg::ACT_INV: begin
            x0 = oad; x1 = oan;
         end
         rau_pkg::ACT_CMP: begin
            x0 = oan; y0 = obd; x1 = obn; y1 = oad;
         end
         default: begin
            x0 = one;
         end
      endcase
      case (cnt_ff)
         2'd0: begin
            mx = x0; my = y0;
         end
         2'd1: begin
            mx = x1; my = y1;
         end
         default: begin
            mx = x2; my = y2;
         end
      endcase
   end

   rau_mul u_mul (
      .clock (clock),
      .x_mag (mx.mag),
      .y_mag (my.mag),
      .prod  (prod)
   );

   // ---------------- combine products, classify the result
   logic                   sub_op, addsub_op, t2_neg, sum_neg, n_neg_c, d_neg_c;
   logic                   lhs_neg, rhs_neg;
   logic [rau_pkg::PW-1:0] sum_mag, n_mag_c, d_mag_c, lhs_s, rhs_s;

   always_comb begin
      sub_op    = (act_ff == rau_pkg::ACT_SUB);
      addsub_op = (act_ff == rau_pkg::ACT_ADD) || sub_op;
      t2_neg    = p_neg_ff[1] ^ sub_op;
      if (p_neg_ff[0] == t2_neg) begin
         sum_mag = p_mag_ff[0] + p_mag_ff[1];
         sum_neg = p_neg_ff[0];
      end else if (p_mag_ff[0] >= p_mag_ff[1]) begin
         sum_mag = p_mag_ff[0] - p_mag_ff[1];
         sum_neg = p_neg_ff[0];
      end else begin
         sum_mag = p_mag_ff[1] - p_mag_ff[0];
         sum_neg = t2_neg;
      end
      n_mag_c = addsub_op ? sum_mag : p_mag_ff[0];
      n_neg_c = addsub_op ? sum_neg : p_neg_ff[0];
      d_mag_c = addsub_op ? p_mag_ff[2] : p_mag_ff[1];
      d_neg_c = addsub_op ? p_neg_ff[2] : p_neg_ff[1];

      // cross products carry the signs of both denominators
      lhs_neg = p_neg_ff[0] ^ ad_ff[rau_pkg::DW-1] ^ bd_ff[rau_pkg::DW-1];
      rhs_neg = p_neg_ff[1] ^ ad_ff[rau_pkg::DW-1] ^ bd_ff[rau_pkg::DW-1];
      lhs_s   = lhs_neg ? (~p_mag_ff[0] + 1'b1) : p_mag_ff[0];
      rhs_s   = rhs_neg ? (~p_mag_ff[1] + 1'b1) : p_mag_ff[1];
      if (ad_ff == '0 || bd_ff == '0) begin
         cmp_c = rau_pkg::CMP_EQ;
      end else if ($signed(lhs_s) > $signed(rhs_s)) begin
         cmp_c = rau_pkg::CMP_AGT;
      end else if ($signed(lhs_s) < $signed(rhs_s)) begin
         cmp_c = rau_pkg::CMP_BGT;
      end else begin
         cmp_c = rau_pkg::CMP_EQ;
      end

      if (act_ff == rau_pkg::ACT_CMP) begin
         kind_c = rau_pkg::K_CMP;
      end else if (act_ff == rau_pkg::ACT_NONE || d_mag_c == '0) begin
         kind_c = rau_pkg::K_UNDEF;
      end else if (n_mag_c == '0) begin
         kind_c = rau_pkg::K_ZERO;
      end else begin
         kind_c = rau_pkg::K_FRAC;
      end
   end

   // ---------------- gcd and exact division by it
   // start from the combined parts, captured in the same cycle as n_mag_ff
   rau_gcd u_gcd (
      .clock   (clock),
      .reset   (reset),
      .start   (gcd_start),
      .x_val   (n_mag_c),
      .y_val   (d_mag_c),
      .stat    (gcd_stat),
      .gcd_val (gcd_val)
   );

   assign div_a = (state_ff == rau_pkg::ST_GCD) ? n_mag_ff : d_mag_ff;
   assign div_b = (state_ff == rau_pkg::ST_GCD) ? gcd_val : g_ff;

   rau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .stat     (div_stat),
      .quotient (quotient)
   );

   // ---------------- saturation and result formatting
   always_comb begin
      logic                   neg;
      logic [rau_pkg::PW-1:0] lim, nm, dm, nbits;
      neg   = n_neg_ff ^ d_neg_ff;
      lim   = neg ? HALF : HALF - 1'b1;
      ovf_c = 1'b0;
      nm    = qn_ff;
      dm    = quotient;
      if (nm > lim) begin
         nm    = lim;
         ovf_c = 1'b1;
      end
      if (dm > HALF - 1'b1) begin
         dm    = HALF - 1'b1;
         ovf_c = 1'b1;
      end
      nbits     = neg ? (~nm + 1'b1) : nm;
      res_num_c = nbits[rau_pkg::DW-1:0];
      res_den_c = dm[rau_pkg::DW-2:0];
   end

   // ---------------- sequencer: next state
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rau_pkg::ST_IDLE: if (req_valid) state_in = rau_pkg::ST_MUL;
         rau_pkg::ST_MUL:  if (cnt_ff == 2'd3) state_in = rau_pkg::ST_SUM;
         rau_pkg::ST_SUM: begin
            state_in = (kind_c == rau_pkg::K_FRAC) ? rau_pkg::ST_GCD : rau_pkg::ST_FIN;
         end
         rau_pkg::ST_GCD:  if (gcd_stat.done) state_in = rau_pkg::ST_DIVN;
         rau_pkg::ST_DIVN: if (div_stat.done) state_in = rau_pkg::ST_DIVD;
         rau_pkg::ST_DIVD: if (div_stat.done) state_in = rau_pkg::ST_FIN;
         rau_pkg::ST_FIN:  if (out_free) state_in = rau_pkg::ST_IDLE;
         default:          state_in = rau_pkg::ST_IDLE;
      endcase
   end

   // ---------------- sequencer: strobes
   always_comb begin
      accept      = 1'b0;
      mul_issue   = 1'b0;
      mul_capture = 1'b0;
      gcd_start   = 1'b0;
      div_start   = 1'b0;
      out_load    = 1'b0;
      case (state_ff)
         rau_pkg::ST_IDLE: accept = req_valid;
         rau_pkg::ST_MUL: begin
            mul_issue   = (cnt_ff != 2'd3);
            mul_capture = (cnt_ff != 2'd0);
         end
         rau_pkg::ST_SUM:  gcd_start = (kind_c == rau_pkg::K_FRAC);
         rau_pkg::ST_GCD:  div_start = gcd_stat.done;
         rau_pkg::ST_DIVN: div_start = div_stat.done;
         rau_pkg::ST_DIVD: div_start = 1'b0;
         rau_pkg::ST_FIN:  out_load  = out_free;
         default:          accept    = 1'b0;
      endcase
   end

   // ---------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rau_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action;
         an_ff  <= req_a_num;
         ad_ff  <= req_a_den;
         bn_ff  <= req_b_num;
         bd_ff  <= req_b_den;
         cnt_ff <= 2'd0;
      end else if (state_ff == rau_pkg::ST_MUL) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (mul_issue) begin
         pend_neg_ff <= mx.neg ^ my.neg;
      end
      if (mul_capture) begin
         p_mag_ff[cnt_ff - 1'b1] <= prod;
         p_neg_ff[cnt_ff - 1'b1] <= pend_neg_ff;
      end
      if (state_ff == rau_pkg::ST_SUM) begin
         n_mag_ff <= n_mag_c;
         n_neg_ff <= n_neg_c;
         d_mag_ff <= d_mag_c;
         d_neg_ff <= d_neg_c;
         kind_ff  <= kind_c;
         cmp_ff   <= cmp_c;
      end
      if (state_ff == rau_pkg::ST_GCD && gcd_stat.done) begin
         g_ff <= gcd_val;
      end
      if (state_ff == rau_pkg::ST_DIVN && div_stat.done) begin
         qn_ff <= quotient;
      end
      if (out_load) begin
         case (kind_ff)
            rau_pkg::K_ZERO: begin
               res_num_ff  <= '0;
               res_den_ff  <= (rau_pkg::DW-1)'(1);
               cmp_code_ff <= rau_pkg::CMP_EQ;
               ovf_ff      <= 1'b0;
            end
            rau_pkg::K_CMP: begin
               res_num_ff  <= '0;
               res_den_ff  <= '0;
               cmp_code_ff <= cmp_ff;
               ovf_ff      <= 1'b0;
            end
            rau_pkg::K_FRAC: begin
               res_num_ff  <= res_num_c;
               res_den_ff  <= res_den_c;
               cmp_code_ff <= rau_pkg::CMP_EQ;
               ovf_ff      <= ovf_c;
            end
            default: begin
               res_num_ff  <= '0;
               res_den_ff  <= '0;
               cmp_code_ff <= rau_pkg::CMP_EQ;
               ovf_ff      <= 1'b0;
            end
         endcase
      end
   end

   assign req_stall    = (state_ff != rau_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_num  = res_num_ff;
   assign rsp_res_den  = res_den_ff;
   assign rsp_cmp_code = cmp_code_ff;
   assign rsp_overflow = ovf_ff;

   // ---------------- assertions
   a_cmp_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cmp_code != rau_pkg::CMP_EQ) |->
         (rsp_res_num == '0 && rsp_res_den == '0 && !rsp_overflow))
      else $error("compare result carries a fraction");

   a_undef: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_res_den == '0) |-> (rsp_res_num == '0 && !rsp_overflow))
      else $error("undefined result with nonzero numerator");

   a_units_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rau_pkg::ST_IDLE) |-> (!gcd_stat.busy && !div_stat.busy))
      else $error("iterative unit busy while idle");

   a_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("finished result not presented");

endmodule

@@ design/rau_mul.sv @@
// Registered DW x DW unsigned multiplier shared by all product steps.
// Depends on rau_pkg.
module rau_mul (
   input  logic                     clock,
   input  logic [rau_pkg::DW-1:0]   x_mag,
   input  logic [rau_pkg::DW-1:0]   y_mag,
   output logic [rau_pkg::PW-1:0]   prod
);

   logic [rau_pkg::PW-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= rau_pkg::PW'(x_mag) * rau_pkg::PW'(y_mag);
   end

   assign prod = prod_ff;

endmodule

@@ design/rau_gcd.sv @@
// Iterative binary gcd of two nonzero PW-bit magnitudes, one step per cycle.
// Depends on rau_pkg.
module rau_gcd (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rau_pkg::PW-1:0]        x_val,
   input  logic [rau_pkg::PW-1:0]        y_val,
   output rau_pkg::unit_stat_type        stat,
   output logic [rau_pkg::PW-1:0]        gcd_val
);

   logic [rau_pkg::PW-1:0] x_ff, x_in, y_ff, y_in, g_ff, g_in;
   logic [rau_pkg::KW-1:0] k_ff, k_in;
   logic                   busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      k_in    = k_ff;
      g_in    = g_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = x_val;
         y_in    = y_val;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_in = x_ff >> 1;
            y_in = y_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff == y_ff) begin
            // both odd and equal: restore the common power of two
            g_in    = x_ff << k_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (x_ff > y_ff) begin
            x_in = x_ff - y_ff;
         end else begin
            y_in = y_ff - x_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      k_ff <= k_in;
      g_ff <= g_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign gcd_val   = g_ff;

endmodule

@@ design/rau_div.sv @@
// Restoring divider for PW-bit magnitudes, one quotient bit per cycle.
// Depends on rau_pkg.
module rau_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rau_pkg::PW-1:0]        dividend,
   input  logic [rau_pkg::PW-1:0]        divisor,
   output rau_pkg::unit_stat_type        stat,
   output logic [rau_pkg::PW-1:0]        quotient
);

   logic [rau_pkg::PW-1:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [rau_pkg::KW-1:0] cnt_ff, cnt_in;
   logic                   busy_ff, busy_in, done_ff, done_in;
   logic [rau_pkg::PW+1:0] diff;

   assign diff = {1'b0, rem_ff, quo_ff[rau_pkg::PW-1]} - {2'b00, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = rau_pkg::KW'(rau_pkg::PW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // keep the trial difference only when it did not borrow
         if (diff[rau_pkg::PW+1]) begin
            rem_in = {rem_ff[rau_pkg::PW-2:0], quo_ff[rau_pkg::PW-1]};
         end else begin
            rem_in = diff[rau_pkg::PW-1:0];
         end
         quo_in = {quo_ff[rau_pkg::PW-2:0], ~diff[rau_pkg::PW+1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

@@ bench/tb_top.sv @@
// Testbench for rational_arithmetic_unit: drives fraction transactions, predicts
// each reduced result or compare code, and checks them in order.
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
`timescale 1ns / 1ps

class frac_scoreboard;
   typedef struct {
      logic signed [31:0] num;
      logic [30:0]        den;
      logic [1:0]         cmp;
      logic               ovf;
   } frac_result_type;

   frac_result_type pending[$];
   int errors;

   function new();
      errors = 0;
   endfunction

   static function longint unsigned gcd_mag(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // reduce n/d given as sign and magnitude, saturate the numerator to 32-bit signed and the denominator to 31 bits
   static function frac_result_type reduce(bit nneg, longint unsigned nmag,
                                           bit dneg, longint unsigned dmag);
      frac_result_type r;
      longint unsigned g, nm, dm, lim;
      bit neg;
      r.num = 0; r.den = 0; r.cmp = rau_pkg::CMP_EQ; r.ovf = 0;
      if (dmag == 0) return r;
      if (nmag == 0) begin
         r.den = 1;
         return r;
      end
      g = gcd_mag(nmag, dmag);
      nm = nmag / g;
      dm = dmag / g;
      neg = nneg != dneg;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (nm > lim) begin
         nm = lim;
         r.ovf = 1;
      end
      if (dm > 64'h7FFF_FFFF) begin
         dm = 64'h7FFF_FFFF;
         r.ovf = 1;
      end
      r.num = neg ? 32'(-nm) : 32'(nm);
      r.den = dm[30:0];
      return r;
   endfunction

   function void note_request(logic [2:0] act, logic signed [31:0] an,
                              logic signed [31:0] ad, logic signed [31:0] bn,
                              logic signed [31:0] bd);
      frac_result_type r;
      longint unsigned man, mad, mbn, mbd, p1, p2, sm;
      bit nan, nad, nbn, nbd, n1, n2, sn;
      longint signed lhs, rhs;
      nan = an < 0; nad = ad < 0; nbn = bn < 0; nbd = bd < 0;
      man = nan ? 64'(-64'(an)) : 64'(an);
      mad = nad ? 64'(-64'(ad)) : 64'(ad);
      mbn = nbn ? 64'(-64'(bn)) : 64'(bn);
      mbd = nbd ? 64'(-64'(bd)) : 64'(bd);
      r.num = 0; r.den = 0; r.cmp = rau_pkg::CMP_EQ; r.ovf = 0;
      case (act)
         rau_pkg::ACT_NORM: r = reduce(nan, man, nad, mad);
         rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
            p1 = man * mbd; n1 = nan != nbd;
            p2 = mbn * mad; n2 = nbn != nad;
            if (act == rau_pkg::ACT_SUB) n2 = !n2;
            if (n1 == n2) begin
               sn = n1; sm = p1 + p2;
            end else if (p1 >= p2) begin
               sn = n1; sm = p1 - p2;
            end else begin
               sn = n2; sm = p2 - p1;
            end
            r = reduce(sn, sm, nad != nbd, mad * mbd);
         end
         rau_pkg::ACT_MUL: r = reduce(nan != nbn, man * mbn, nad != nbd, mad * mbd);
         rau_pkg::ACT_DIV: r = reduce(nan != nbd, man * mbd, nad != nbn, mad * mbn);
         rau_pkg::ACT_INV: r = reduce(nad, mad, nan, man);
         rau_pkg::ACT_CMP: begin
            if (ad != 0 && bd != 0) begin
               lhs = 64'(an) * longint'(mbd);
               rhs = 64'(bn) * longint'(mad);
               if (nad) lhs = -lhs;
               if (nbd) rhs = -rhs;
               r.cmp = lhs > rhs ? rau_pkg::CMP_AGT :
                       (lhs < rhs ? rau_pkg::CMP_BGT : rau_pkg::CMP_EQ);
            end
         end
         default: ;
      endcase
      pending.push_back(r);
   endfunction

   function void check_result(logic signed [31:0] num, logic [30:0] den,
                              logic [1:0] cmp, logic ovf);
      frac_result_type e;
      if (pending.size() == 0) begin
         report_mismatch("result with nothing outstanding", 0, 0);
         return;
      end
      e = pending.pop_front();
      if (num !== e.num) report_mismatch("res_num", num, e.num);
      if (den !== e.den) report_mismatch("res_den", den, e.den);
      if (cmp !== e.cmp) report_mismatch("cmp_code", cmp, e.cmp);
      if (ovf !== e.ovf) report_mismatch("overflow", ovf, e.ovf);
   endfunction

   function void report_mismatch(string what, longint got, longint want);
      errors++;
      if (errors <= 40)
         $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endfunction
endclass

module tb_top;

   localparam int STALL_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [2:0] req_action = '0;
   logic signed [31:0] req_a_num = '0, req_a_den = '0, req_b_num = '0, req_b_den = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_res_num;
   logic [30:0] rsp_res_den;
   logic [1:0] rsp_cmp_code;
   logic rsp_overflow;

   frac_scoreboard board = new();
   bit calm = 0;          // stretch with no idling on either side
   bit hold_off = 0;      // long receiver stall to back up the block
   int quiet_cycles = 0;

   always #1 clock = ~clock;

   rational_arithmetic_unit uut (.*);

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_request(req_action, req_a_num, req_a_den, req_b_num, req_b_den);
         if (rsp_valid && !rsp_stall)
            board.check_result(rsp_res_num, rsp_res_den, rsp_cmp_code, rsp_overflow);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > STALL_LIMIT) begin
            $display("rational_arithmetic_unit verification failed");
            $finish;
         end
      end
   end

   // receiver: random stall, none during the calm stretch, solid during hold-off
   always @(negedge clock) begin
      if (hold_off)
         rsp_stall <= 1;
      else
         rsp_stall <= !calm && ($urandom_range(99) < 12);
   end

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 0;
         3, 4: return $signed(32'($urandom_range(40))) - 20;
         5, 6: return $signed(32'($urandom_range(2000))) - 1000;
         7: return $signed(32'($urandom_range(65535))) - 32768;
         default: return $signed($urandom);
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_fraction(logic [2:0] act, logic signed [31:0] an,
                                logic signed [31:0] ad, logic signed [31:0] bn,
                                logic signed [31:0] bd);
      while (!calm && $urandom_range(99) < 12) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_action <= act;
      req_a_num <= an; req_a_den <= ad; req_b_num <= bn; req_b_den <= bd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [2:0] a;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: every action, zero and extreme operands
      send_fraction(rau_pkg::ACT_NORM, 6, -4, 0, 0);
      send_fraction(rau_pkg::ACT_NORM, 5, 0, 0, 0);
      send_fraction(rau_pkg::ACT_NORM, 0, -7, 0, 0);
      send_fraction(rau_pkg::ACT_NORM, 32'sh8000_0000, -1, 0, 0);
      send_fraction(rau_pkg::ACT_NORM, 32'sh8000_0000, 1, 0, 0);
      send_fraction(rau_pkg::ACT_NORM, 1, 32'sh8000_0000, 0, 0);
      send_fraction(rau_pkg::ACT_ADD, 1, 2, 1, 3);
      send_fraction(rau_pkg::ACT_ADD, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 1);
      send_fraction(rau_pkg::ACT_SUB, 1, 2, 1, 2);
      send_fraction(rau_pkg::ACT_SUB, 32'sh8000_0000, 32'sh7FFF_FFFF,
                    32'sh7FFF_FFFF, 32'sh8000_0000);
      send_fraction(rau_pkg::ACT_MUL, 3, 4, -8, 9);
      send_fraction(rau_pkg::ACT_MUL, 7, 1, 5, 1);
      send_fraction(rau_pkg::ACT_MUL, 32'sh8000_0000, 1, 32'sh8000_0000, 1);
      send_fraction(rau_pkg::ACT_DIV, 2, 3, 0, 5);
      send_fraction(rau_pkg::ACT_DIV, 2, 0, 4, 5);
      send_fraction(rau_pkg::ACT_DIV, -2, 3, 4, -5);
      send_fraction(rau_pkg::ACT_INV, 0, 5, 0, 0);
      send_fraction(rau_pkg::ACT_INV, -3, 9, 0, 0);
      send_fraction(rau_pkg::ACT_CMP, 1, 2, 2, 4);
      send_fraction(rau_pkg::ACT_CMP, 1, -2, 1, 3);
      send_fraction(rau_pkg::ACT_CMP, 1, 0, 5, 3);
      send_fraction(rau_pkg::ACT_CMP, 32'sh8000_0000, 1, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_fraction(rau_pkg::ACT_NONE, 1, 1, 1, 1);

      // back up the block: receiver holds off while requests keep coming
      fork
         begin
            hold_off = 1;
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end
         repeat (6) send_fraction(rau_pkg::ACT_ADD, pick_value(), pick_value(),
                                  pick_value(), pick_value());
      join

      for (int i = 0; i < 1620; i++) begin
         calm = (i >= 600 && i < 800);
         a = (i % 50 == 0) ? rau_pkg::ACT_NONE : 3'($urandom_range(6));
         send_fraction(a, pick_value(), pick_value(), pick_value(), pick_value());
      end
      calm = 0;
      req_valid <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (board.errors == 0)
         $display("rational_arithmetic_unit verification clean");
      else
         $display("rational_arithmetic_unit verification failed");
      $finish;
   end
endmodule
